// ===== rtl/core/hcrc_pkg.sv =====
package hcrc_pkg;

	localparam logic [2:0] PH_PREFIX      = 3'd0;
	localparam logic [2:0] PH_DIGITS      = 3'd1;
	localparam logic [2:0] PH_SPACE       = 3'd2;
	localparam logic [2:0] PH_STATUS_REST = 3'd3;
	localparam logic [2:0] PH_HEADERS     = 3'd4;
	localparam logic [2:0] PH_ESTABLISHED = 3'd5;
	localparam logic [2:0] PH_MALFORMED   = 3'd6;
	localparam logic [2:0] PH_BAD_STATUS  = 3'd7;

	localparam logic [1:0] VERDICT_BUSY        = 2'd0;
	localparam logic [1:0] VERDICT_ESTABLISHED = 2'd1;
	localparam logic [1:0] VERDICT_MALFORMED   = 2'd2;
	localparam logic [1:0] VERDICT_BAD_STATUS  = 2'd3;

	localparam logic [3:0] PREFIX_LEN = 4'd9;
	localparam logic [1:0] DIGIT_COUNT = 2'd3;
	localparam logic [9:0] STATUS_LOW  = 10'd200;
	localparam logic [9:0] STATUS_HIGH = 10'd300;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DEL   = 8'h7f;

	typedef struct packed {
		logic [2:0] phase;
		logic [3:0] prefix_pos;
		logic [9:0] status;
		logic       saw_cr;
		logic       at_line_start;
		logic       in_field_name;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_PREFIX,
		prefix_pos: 4'd0,
		status: 10'd0,
		saw_cr: 1'b0,
		at_line_start: 1'b0,
		in_field_name: 1'b0
	};

	function automatic logic [7:0] prefix_char(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0: ch = 8'h48;
			4'd1: ch = 8'h54;
			4'd2: ch = 8'h54;
			4'd3: ch = 8'h50;
			4'd4: ch = 8'h2f;
			4'd5: ch = 8'h31;
			4'd6: ch = 8'h2e;
			4'd7: ch = 8'h31;
			default: ch = CH_SPACE;
		endcase
		return ch;
	endfunction

	function automatic logic is_valid_char(input logic [7:0] c);
		logic ok;
		if (c >= CH_DEL) begin
			ok = 1'b0;
		end else if (c < CH_SPACE) begin
			ok = (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
		end else begin
			ok = 1'b1;
		end
		return ok;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_token_char(input logic [7:0] c);
		logic ok;
		ok = is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
			8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

endpackage

// ===== rtl/core/hcrc_step.sv =====
module hcrc_step (
	input  hcrc_pkg::parse_state_t cur,
	input  logic [7:0]             data_byte,
	input  logic                   begin_req,
	output hcrc_pkg::parse_state_t nxt,
	output logic [1:0]             verdict
);

	hcrc_pkg::parse_state_t st;
	logic                   valid_c;
	logic                   bare_lf;
	logic [9:0]             times_ten;

	always_comb begin
		st = begin_req ? hcrc_pkg::STATE_RESET : cur;
		nxt = st;
		valid_c = hcrc_pkg::is_valid_char(data_byte);
		bare_lf = !st.saw_cr && (data_byte == hcrc_pkg::CH_LF);
		times_ten = {st.status[6:0], 3'b000} + {st.status[8:0], 1'b0};

		case (st.phase)
			hcrc_pkg::PH_PREFIX: begin
				if (st.prefix_pos < hcrc_pkg::PREFIX_LEN
						&& data_byte == hcrc_pkg::prefix_char(st.prefix_pos)) begin
					if (st.prefix_pos + 4'd1 >= hcrc_pkg::PREFIX_LEN) begin
						nxt.phase = hcrc_pkg::PH_DIGITS;
						nxt.prefix_pos = 4'd0;
					end else begin
						nxt.prefix_pos = st.prefix_pos + 4'd1;
					end
				end else begin
					nxt.phase = hcrc_pkg::PH_MALFORMED;
				end
			end
			hcrc_pkg::PH_DIGITS: begin
				if (hcrc_pkg::is_digit(data_byte)) begin
					nxt.status = times_ten + {6'd0, data_byte[3:0]};
					nxt.prefix_pos = st.prefix_pos + 4'd1;
					if (st.prefix_pos + 4'd1 >= {2'd0, hcrc_pkg::DIGIT_COUNT}) begin
						nxt.phase = hcrc_pkg::PH_SPACE;
					end
				end else begin
					nxt.phase = hcrc_pkg::PH_MALFORMED;
				end
			end
			hcrc_pkg::PH_SPACE: begin
				if (data_byte != hcrc_pkg::CH_SPACE) begin
					nxt.phase = hcrc_pkg::PH_MALFORMED;
				end else if (st.status < hcrc_pkg::STATUS_LOW
						|| st.status >= hcrc_pkg::STATUS_HIGH) begin
					nxt.phase = hcrc_pkg::PH_BAD_STATUS;
				end else begin
					nxt.phase = hcrc_pkg::PH_STATUS_REST;
				end
			end
			hcrc_pkg::PH_STATUS_REST: begin
				if (!valid_c || bare_lf) begin
					nxt.phase = hcrc_pkg::PH_MALFORMED;
				end else if (st.saw_cr) begin
					if (data_byte != hcrc_pkg::CH_LF) begin
						nxt.phase = hcrc_pkg::PH_MALFORMED;
					end else begin
						nxt.saw_cr = 1'b0;
						nxt.at_line_start = 1'b1;
						nxt.phase = hcrc_pkg::PH_HEADERS;
					end
				end else begin
					nxt.saw_cr = (data_byte == hcrc_pkg::CH_CR);
				end
			end
			hcrc_pkg::PH_HEADERS: begin
				if (!valid_c || bare_lf) begin
					nxt.phase = hcrc_pkg::PH_MALFORMED;
				end else if (st.saw_cr) begin
					if (data_byte != hcrc_pkg::CH_LF) begin
						nxt.phase = hcrc_pkg::PH_MALFORMED;
					end else if (st.at_line_start) begin
						// blank line closes the header block
						nxt.phase = hcrc_pkg::PH_ESTABLISHED;
					end else begin
						nxt.saw_cr = 1'b0;
						nxt.at_line_start = 1'b1;
					end
				end else if (st.in_field_name) begin
					if (data_byte == hcrc_pkg::CH_COLON) begin
						nxt.in_field_name = 1'b0;
					end else if (!hcrc_pkg::is_token_char(data_byte)) begin
						nxt.phase = hcrc_pkg::PH_MALFORMED;
					end
				end else if (st.at_line_start) begin
					if (data_byte == hcrc_pkg::CH_CR) begin
						nxt.saw_cr = 1'b1;
					end else if (hcrc_pkg::is_token_char(data_byte)) begin
						nxt.at_line_start = 1'b0;
						nxt.in_field_name = 1'b1;
					end else begin
						nxt.phase = hcrc_pkg::PH_MALFORMED;
					end
				end else begin
					nxt.saw_cr = (data_byte == hcrc_pkg::CH_CR);
				end
			end
			default: ;
		endcase

		case (nxt.phase)
			hcrc_pkg::PH_ESTABLISHED: verdict = hcrc_pkg::VERDICT_ESTABLISHED;
			hcrc_pkg::PH_MALFORMED:   verdict = hcrc_pkg::VERDICT_MALFORMED;
			hcrc_pkg::PH_BAD_STATUS:  verdict = hcrc_pkg::VERDICT_BAD_STATUS;
			default:                  verdict = hcrc_pkg::VERDICT_BUSY;
		endcase
	end

endmodule

// ===== rtl/core/http_connect_reply_checker_core.sv =====
// Checks a proxy's reply to an HTTP CONNECT request, one byte per transaction. Every byte
// gives one result: verdict (0 in progress, 1 established, 2 malformed, 3 status not 2xx)
// and the status code gathered so far; a verdict other than 0 holds until a byte arrives
// with the begin flag set, which restarts the parser on that byte. A byte passes through the input
// register, then the parser state update, then the result register; the block takes one byte every
// cycle unless the result register holds an unaccepted result while m_tready is low.
module http_connect_reply_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] begin_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] verdict, [11:2] status_code, [15:12] zero
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   begin_s1;
	logic                   valid_s2;
	logic [1:0]             verdict_s2;
	logic [9:0]             status_s2;
	hcrc_pkg::parse_state_t state_q;
	hcrc_pkg::parse_state_t state_nxt;
	logic [1:0]             verdict_nxt;
	logic                   advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	hcrc_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.begin_req (begin_s1),
		.nxt       (state_nxt),
		.verdict   (verdict_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= hcrc_pkg::STATE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			begin_s1 <= s_tuser;
		end
		if (advance) begin
			verdict_s2 <= verdict_nxt;
			status_s2  <= state_nxt.status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, status_s2, verdict_s2};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 750;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LONG_HOLD     = 150;

	typedef struct packed {
		logic [1:0] verdict;
		logic [9:0] status;
	} reply_result_t;

	typedef struct packed {
		logic [7:0]    data;
		logic          first;
		logic          typed;
		reply_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [15:0] m_tdata;

	string token_set =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!#$%&'*+-.^_|~";
	string reply_prefix = "HTTP/1.1 ";

	// parser state mirrored by the predictor
	logic [2:0] pr_phase;
	logic [3:0] pr_pos;
	logic [9:0] pr_status;
	logic       pr_cr;
	logic       pr_line_start;
	logic       pr_in_name;

	reply_result_t pending_verdicts[$];
	stim_row_t     directed_rows[$];
	logic [7:0]    reply_bytes[$];
	logic          reply_first;

	int cycle_count = 0;
	int error_count = 0;
	int useful_count = 0;
	int src_idle_pct = 31;
	int sink_idle_pct = 47;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	http_connect_reply_checker_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic char_allowed(input logic [7:0] c);
		return (c == hcrc_pkg::CH_TAB) || (c == hcrc_pkg::CH_LF) || (c == hcrc_pkg::CH_CR)
			|| (c >= hcrc_pkg::CH_SPACE && c < hcrc_pkg::CH_DEL);
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		logic hit;
		hit = (c == 8'h60);
		for (int i = 0; i < token_set.len(); i++) begin
			if (c == token_set[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic void clear_parser();
		pr_phase = hcrc_pkg::PH_PREFIX;
		pr_pos = 4'd0;
		pr_status = 10'd0;
		pr_cr = 1'b0;
		pr_line_start = 1'b0;
		pr_in_name = 1'b0;
	endfunction

	function automatic reply_result_t advance_parser(input logic [7:0] c, input logic first);
		reply_result_t r;
		logic good;
		if (first) clear_parser();
		// a bare lf is as bad as a control byte
		good = char_allowed(c) && !(c == hcrc_pkg::CH_LF && !pr_cr);
		case (pr_phase)
			hcrc_pkg::PH_PREFIX: begin
				if (pr_pos < hcrc_pkg::PREFIX_LEN && c == reply_prefix[pr_pos]) begin
					pr_pos = pr_pos + 4'd1;
					if (pr_pos >= hcrc_pkg::PREFIX_LEN) begin
						pr_phase = hcrc_pkg::PH_DIGITS;
						pr_pos = 4'd0;
					end
				end else begin
					pr_phase = hcrc_pkg::PH_MALFORMED;
				end
			end
			hcrc_pkg::PH_DIGITS: begin
				if (c >= 8'h30 && c <= 8'h39) begin
					pr_status = pr_status * 10'd10 + {2'b00, c - 8'h30};
					pr_pos = pr_pos + 4'd1;
					if (pr_pos >= hcrc_pkg::DIGIT_COUNT) pr_phase = hcrc_pkg::PH_SPACE;
				end else begin
					pr_phase = hcrc_pkg::PH_MALFORMED;
				end
			end
			hcrc_pkg::PH_SPACE: begin
				if (c != hcrc_pkg::CH_SPACE) pr_phase = hcrc_pkg::PH_MALFORMED;
				else if (pr_status < hcrc_pkg::STATUS_LOW || pr_status >= hcrc_pkg::STATUS_HIGH)
					pr_phase = hcrc_pkg::PH_BAD_STATUS;
				else pr_phase = hcrc_pkg::PH_STATUS_REST;
			end
			hcrc_pkg::PH_STATUS_REST: begin
				if (!good) begin
					pr_phase = hcrc_pkg::PH_MALFORMED;
				end else if (pr_cr) begin
					if (c != hcrc_pkg::CH_LF) begin
						pr_phase = hcrc_pkg::PH_MALFORMED;
					end else begin
						pr_cr = 1'b0;
						pr_line_start = 1'b1;
						pr_phase = hcrc_pkg::PH_HEADERS;
					end
				end else begin
					pr_cr = (c == hcrc_pkg::CH_CR);
				end
			end
			hcrc_pkg::PH_HEADERS: begin
				if (!good) begin
					pr_phase = hcrc_pkg::PH_MALFORMED;
				end else if (pr_cr) begin
					if (c != hcrc_pkg::CH_LF) begin
						pr_phase = hcrc_pkg::PH_MALFORMED;
					end else if (pr_line_start) begin
						// empty line ends the header block
						pr_phase = hcrc_pkg::PH_ESTABLISHED;
					end else begin
						pr_cr = 1'b0;
						pr_line_start = 1'b1;
					end
				end else if (pr_in_name) begin
					if (!is_name_char(c)) begin
						if (c == hcrc_pkg::CH_COLON) pr_in_name = 1'b0;
						else pr_phase = hcrc_pkg::PH_MALFORMED;
					end
				end else if (pr_line_start) begin
					if (c == hcrc_pkg::CH_CR) begin
						pr_cr = 1'b1;
					end else if (is_name_char(c)) begin
						pr_line_start = 1'b0;
						pr_in_name = 1'b1;
					end else begin
						pr_phase = hcrc_pkg::PH_MALFORMED;
					end
				end else begin
					pr_cr = (c == hcrc_pkg::CH_CR);
				end
			end
			default: ;
		endcase
		case (pr_phase)
			hcrc_pkg::PH_ESTABLISHED: r.verdict = hcrc_pkg::VERDICT_ESTABLISHED;
			hcrc_pkg::PH_MALFORMED:   r.verdict = hcrc_pkg::VERDICT_MALFORMED;
			hcrc_pkg::PH_BAD_STATUS:  r.verdict = hcrc_pkg::VERDICT_BAD_STATUS;
			default:                  r.verdict = hcrc_pkg::VERDICT_BUSY;
		endcase
		r.status = pr_status;
		return r;
	endfunction

	function automatic void add_row(input logic [7:0] data, input logic first, input logic typed,
			input logic [1:0] verdict, input logic [9:0] status);
		stim_row_t row;
		row.data = data;
		row.first = first;
		row.typed = typed;
		row.res.verdict = verdict;
		row.res.status = status;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [7:0] token_pick();
		if ($urandom_range(19) == 0) return 8'h60;
		return token_set[$urandom_range(token_set.len() - 1)];
	endfunction

	task automatic add_text(input int n);
		logic [7:0] v;
		repeat (n) begin
			if ($urandom_range(9) == 0) v = hcrc_pkg::CH_TAB;
			else v = 8'($urandom_range(8'h7e, 8'h20));
			reply_bytes.push_back(v);
		end
	endtask

	// one reply: mostly well formed, some with a damaged or missing tail, some pure noise
	task automatic build_reply();
		int code;
		int nh;
		int pos;
		logic [7:0] v;
		reply_bytes.delete();
		reply_first = ($urandom_range(7) != 0);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(6, 1)) reply_bytes.push_back(8'($urandom_range(255)));
			return;
		end
		for (int i = 0; i < reply_prefix.len(); i++) reply_bytes.push_back(reply_prefix[i]);
		case ($urandom_range(9))
			0: code = 0;
			1: code = 999;
			2: code = $urandom_range(999);
			default: code = 200 + $urandom_range(99);
		endcase
		v = 8'(8'h30 + code / 100);
		reply_bytes.push_back(v);
		v = 8'(8'h30 + (code / 10) % 10);
		reply_bytes.push_back(v);
		v = 8'(8'h30 + code % 10);
		reply_bytes.push_back(v);
		reply_bytes.push_back(hcrc_pkg::CH_SPACE);
		add_text($urandom_range(8));
		reply_bytes.push_back(hcrc_pkg::CH_CR);
		reply_bytes.push_back(hcrc_pkg::CH_LF);
		nh = $urandom_range(3);
		repeat (nh) begin
			repeat ($urandom_range(6, 1)) reply_bytes.push_back(token_pick());
			reply_bytes.push_back(hcrc_pkg::CH_COLON);
			add_text($urandom_range(8));
			reply_bytes.push_back(hcrc_pkg::CH_CR);
			reply_bytes.push_back(hcrc_pkg::CH_LF);
		end
		reply_bytes.push_back(hcrc_pkg::CH_CR);
		reply_bytes.push_back(hcrc_pkg::CH_LF);
		pos = $urandom_range(reply_bytes.size() - 1);
		case ($urandom_range(9))
			0, 1: reply_bytes[pos] = 8'($urandom_range(255));
			2: begin
				case ($urandom_range(4))
					0: v = hcrc_pkg::CH_LF;
					1: v = hcrc_pkg::CH_CR;
					2: v = hcrc_pkg::CH_DEL;
					3: v = 8'(8'h80 | $urandom_range(127));
					default: v = 8'($urandom_range(31));
				endcase
				reply_bytes[pos] = v;
			end
			3: begin
				while (reply_bytes.size() > pos) void'(reply_bytes.pop_back());
			end
			default: ;
		endcase
		// trailing bytes land after the verdict and should be ignored
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1)) reply_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first, input logic typed,
			input reply_result_t typed_res);
		reply_result_t got;
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		useful_count++;
		got = advance_parser(b, first);
		pending_verdicts.push_back(typed ? typed_res : got);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		reply_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual verdict %0d status %0d",
					$time, m_tdata[1:0], m_tdata[11:2]);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[1:0] != want.verdict) begin
					$display("%0t: verdict mismatch, expected %0d actual %0d",
						$time, want.verdict, m_tdata[1:0]);
					error_count++;
				end
				if (m_tdata[11:2] != want.status) begin
					$display("%0t: status_code mismatch, expected %0d actual %0d",
						$time, want.status, m_tdata[11:2]);
					error_count++;
				end
				if (m_tdata[15:12] != 4'd0) begin
					$display("%0t: padding mismatch, expected 0 actual %0h",
						$time, m_tdata[15:12]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("http_connect_reply_checker_core regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int base;
		int stage;
		clear_parser();

		// first byte right after reset, extremes, sticky verdicts
		add_row("H", 1'b0, 1'b1, hcrc_pkg::VERDICT_BUSY, 10'd0);
		add_row(8'hff, 1'b0, 1'b1, hcrc_pkg::VERDICT_MALFORMED, 10'd0);
		add_row("T", 1'b0, 1'b1, hcrc_pkg::VERDICT_MALFORMED, 10'd0);
		add_row(8'h00, 1'b1, 1'b1, hcrc_pkg::VERDICT_MALFORMED, 10'd0);
		add_row(hcrc_pkg::CH_DEL, 1'b1, 1'b1, hcrc_pkg::VERDICT_MALFORMED, 10'd0);
		add_row(8'h80, 1'b1, 1'b1, hcrc_pkg::VERDICT_MALFORMED, 10'd0);
		add_row("H", 1'b1, 1'b0, hcrc_pkg::VERDICT_BUSY, 10'd0);
		for (int i = 1; i < reply_prefix.len(); i++) begin
			add_row(reply_prefix[i], 1'b0, 1'b0, hcrc_pkg::VERDICT_BUSY, 10'd0);
		end
		add_row("9", 1'b0, 1'b0, hcrc_pkg::VERDICT_BUSY, 10'd0);
		add_row("9", 1'b0, 1'b0, hcrc_pkg::VERDICT_BUSY, 10'd0);
		add_row("9", 1'b0, 1'b0, hcrc_pkg::VERDICT_BUSY, 10'd0);
		add_row(hcrc_pkg::CH_SPACE, 1'b0, 1'b1, hcrc_pkg::VERDICT_BAD_STATUS, 10'd999);
		add_row("x", 1'b0, 1'b1, hcrc_pkg::VERDICT_BAD_STATUS, 10'd999);
		add_row("H", 1'b1, 1'b1, hcrc_pkg::VERDICT_BUSY, 10'd0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].typed,
				directed_rows[i].res);
		end

		base = useful_count;
		stage = 0;
		while (useful_count < base + RANDOM_ITEMS) begin
			if (stage == 0 && useful_count >= base + RANDOM_ITEMS / 3) begin
				stage = 1;
				src_idle_pct = 47;
				sink_idle_pct = 31;
				pause_until_drained();
			end
			if (stage == 1 && useful_count >= base + 2 * RANDOM_ITEMS / 3) begin
				stage = 2;
				src_idle_pct = 0;
				sink_idle_pct = 0;
				// long receiver stall while the sender keeps pushing
				hold_req++;
			end
			build_reply();
			foreach (reply_bytes[i]) begin
				send_byte(reply_bytes[i], (i == 0) ? reply_first : 1'b0, 1'b0, '0);
			end
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("http_connect_reply_checker_core regression: pass");
		end else begin
			$display("http_connect_reply_checker_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hcrc_pkg.sv
rtl/core/hcrc_step.sv
rtl/core/http_connect_reply_checker_core.sv
tb/tb_top.sv
